>>> rtl/lrbc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the link reconnect backoff controller.
// No dependencies.
package lrbc_pkg;

  localparam int TIME_BITS = 32;   // width of the seconds timebase
  localparam int ADDR_BITS = 5;    // eight 32-bit registers

  typedef logic [2:0]           status_t;
  typedef logic [TIME_BITS-1:0] time_t;

  // status codes
  localparam status_t ST_NOKEY      = 3'd0;
  localparam status_t ST_DISABLED   = 3'd1;
  localparam status_t ST_ZOOMED     = 3'd2;
  localparam status_t ST_CONNECTING = 3'd3;
  localparam status_t ST_CONNECTED  = 3'd4;
  localparam status_t ST_RETRYING   = 3'd5;
  localparam status_t ST_OFFLINE    = 3'd6;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_OFFLINE  = 3'd0;
  localparam logic [2:0] REG_KEY      = 3'd1;
  localparam logic [2:0] REG_BO_START = 3'd2;
  localparam logic [2:0] REG_BO_CAP   = 3'd3;
  localparam logic [2:0] REG_COOLDOWN = 3'd4;
  localparam logic [2:0] REG_SWEEP    = 3'd5;
  localparam logic [2:0] REG_ALT      = 3'd6;
  localparam logic [2:0] REG_SPAN     = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_BO_START = 8'd5;
  localparam logic [11:0] RST_BO_CAP   = 12'd60;
  localparam logic [7:0]  RST_COOLDOWN = 8'd10;
  localparam logic [7:0]  RST_SWEEP    = 8'd10;
  localparam logic [26:0] RST_ALT      = 27'd15000000;
  localparam logic [15:0] RST_SPAN     = 16'd15000;

endpackage

>>> rtl/link_reconnect_backoff_controller_unit.sv
`timescale 1ns / 1ps
// An accepted tick beat is held in the input register, then its result in the
// result register; throughput is one beat per cycle unless out_ready stalls.
// The whole decision (gates, cooldown, backoff doubling, retry time) is one
// pass of compare/add logic between the input register and result register.
// rst_n is synchronous, active low: clears control state, the link/backoff
// state and loads the registers with their reset values. Depends on lrbc_pkg.
module link_reconnect_backoff_controller_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_enabled,
  input  logic [31:0]          in_now_sec,
  input  logic [26:0]          in_cam_alt_m,
  input  logic [15:0]          in_lon_span_centideg,
  input  logic                 in_link_closed,
  input  logic                 in_link_opened,
  input  logic                 in_needs_resubscribe,
  input  logic                 in_open_fails,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output lrbc_pkg::status_t    out_status,
  output logic                 out_drop_link,
  output logic                 out_open_link,
  output logic                 out_sweep_now,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [lrbc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lrbc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        offline_r;
  logic        key_r;
  logic [7:0]  bo_start_r;
  logic [11:0] bo_cap_r;
  logic [7:0]  cooldown_r;
  logic [7:0]  sweep_per_r;
  logic [26:0] alt_lim_r;
  logic [15:0] span_lim_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_r   <= 1'b0;
      key_r       <= 1'b0;
      bo_start_r  <= RST_BO_START;
      bo_cap_r    <= RST_BO_CAP;
      cooldown_r  <= RST_COOLDOWN;
      sweep_per_r <= RST_SWEEP;
      alt_lim_r   <= RST_ALT;
      span_lim_r  <= RST_SPAN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OFFLINE:  offline_r   <= pwdata[0];
        REG_KEY:      key_r       <= pwdata[0];
        REG_BO_START: bo_start_r  <= pwdata[7:0];
        REG_BO_CAP:   bo_cap_r    <= pwdata[11:0];
        REG_COOLDOWN: cooldown_r  <= pwdata[7:0];
        REG_SWEEP:    sweep_per_r <= pwdata[7:0];
        REG_ALT:      alt_lim_r   <= pwdata[26:0];
        REG_SPAN:     span_lim_r  <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_OFFLINE:  prdata = {31'd0, offline_r};
      REG_KEY:      prdata = {31'd0, key_r};
      REG_BO_START: prdata = {24'd0, bo_start_r};
      REG_BO_CAP:   prdata = {20'd0, bo_cap_r};
      REG_COOLDOWN: prdata = {24'd0, cooldown_r};
      REG_SWEEP:    prdata = {24'd0, sweep_per_r};
      REG_ALT:      prdata = {5'd0, alt_lim_r};
      REG_SPAN:     prdata = {16'd0, span_lim_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. The held beat is processed when the result register is
  // free or being drained; the link state commits on that same edge, so the
  // next beat always sees the state this one leaves.
  // ---------------------------------------------------------------------------
  logic        s1_valid_r;
  logic        s1_enabled_r;
  time_t       s1_now_r;
  logic [26:0] s1_alt_r;
  logic [15:0] s1_span_r;
  logic        s1_closed_r;
  logic        s1_opened_r;
  logic        s1_resub_r;
  logic        s1_fails_r;

  logic out_valid_r;
  logic adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_enabled_r <= in_enabled;
      s1_now_r     <= in_now_sec[TIME_BITS-1:0];
      s1_alt_r     <= in_cam_alt_m;
      s1_span_r    <= in_lon_span_centideg;
      s1_closed_r  <= in_link_closed;
      s1_opened_r  <= in_link_opened;
      s1_resub_r   <= in_needs_resubscribe;
      s1_fails_r   <= in_open_fails;
    end
  end

  // ---------------------------------------------------------------------------
  // Link state
  // ---------------------------------------------------------------------------
  logic [11:0] backoff_r,   backoff_nxt;
  time_t       next_retry_r, next_retry_nxt;
  time_t       last_conn_r, last_conn_nxt;
  logic        ever_conn_r, ever_conn_nxt;
  logic [7:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic        held_r,      held_nxt;
  status_t     status_r,    status_nxt;
  logic        drop_nxt, open_nxt, sweep_nxt;

  // shared helpers
  logic [TIME_BITS:0]   retry_sum;
  time_t                retry_time;    // now + backoff, saturated
  logic [TIME_BITS:0]   start_sum;
  time_t                start_time;    // now + start value, saturated
  logic [12:0]          bo_dbl;
  logic [11:0]          bo_next;       // min(2*backoff, cap)
  time_t                since_conn;
  logic                 cool_ok;
  logic [8:0]           sweep_inc;
  logic                 zoom_out;
  logic                 retry_due;

  assign retry_sum  = {1'b0, s1_now_r} + {{(TIME_BITS-11){1'b0}}, backoff_r};
  assign retry_time = retry_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : retry_sum[TIME_BITS-1:0];
  assign start_sum  = {1'b0, s1_now_r} + {{(TIME_BITS-7){1'b0}}, bo_start_r};
  assign start_time = start_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : start_sum[TIME_BITS-1:0];
  assign bo_dbl     = {backoff_r, 1'b0};
  assign bo_next    = (bo_dbl < {1'b0, bo_cap_r}) ? bo_dbl[11:0] : bo_cap_r;

  // cooldown: never connected passes; time running backwards fails
  assign since_conn = s1_now_r - last_conn_r;
  assign cool_ok    = !ever_conn_r ||
                      ((s1_now_r >= last_conn_r) &&
                       (since_conn > {{(TIME_BITS-8){1'b0}}, cooldown_r}));

  assign sweep_inc = {1'b0, sweep_cnt_r} + 9'd1;
  assign zoom_out  = (s1_alt_r > alt_lim_r) || (s1_span_r > span_lim_r);
  assign retry_due = (s1_now_r >= next_retry_r);

  always_comb begin
    backoff_nxt    = backoff_r;
    next_retry_nxt = next_retry_r;
    last_conn_nxt  = last_conn_r;
    ever_conn_nxt  = ever_conn_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    held_nxt       = held_r;
    status_nxt     = status_r;
    drop_nxt       = 1'b0;
    open_nxt       = 1'b0;
    sweep_nxt      = 1'b0;

    if (offline_r) begin
      status_nxt = ST_OFFLINE;
    end else if (!key_r) begin
      status_nxt = ST_NOKEY;
    end else if (!s1_enabled_r) begin
      drop_nxt   = held_r;
      held_nxt   = 1'b0;
      status_nxt = ST_DISABLED;
    end else begin
      // sweep divider runs on every active tick
      if (sweep_inc >= {1'b0, sweep_per_r}) begin
        sweep_cnt_nxt = '0;
        sweep_nxt     = 1'b1;
      end else begin
        sweep_cnt_nxt = sweep_inc[7:0];
      end

      if (zoom_out) begin
        drop_nxt   = held_r;
        held_nxt   = 1'b0;
        status_nxt = ST_ZOOMED;
      end else if (held_r) begin
        if (s1_closed_r) begin
          drop_nxt       = 1'b1;
          held_nxt       = 1'b0;
          next_retry_nxt = retry_time;
          backoff_nxt    = bo_next;
          status_nxt     = ST_RETRYING;
        end else if (s1_opened_r) begin
          backoff_nxt = {4'd0, bo_start_r};
          status_nxt  = ST_CONNECTED;
          if (s1_resub_r && cool_ok) begin
            // reopen: the failure path retries after the start value
            drop_nxt      = 1'b1;
            open_nxt      = 1'b1;
            last_conn_nxt = s1_now_r;
            ever_conn_nxt = 1'b1;
            if (!s1_fails_r) begin
              held_nxt   = 1'b1;
              status_nxt = ST_CONNECTING;
            end else begin
              held_nxt       = 1'b0;
              next_retry_nxt = start_time;
              backoff_nxt    = ({4'd0, bo_start_r, 1'b0} < {1'b0, bo_cap_r}) ?
                               {3'd0, bo_start_r, 1'b0} : bo_cap_r;
              status_nxt     = ST_RETRYING;
            end
          end
        end else begin
          status_nxt = ST_CONNECTING;
        end
      end else if (retry_due && cool_ok) begin
        open_nxt      = 1'b1;
        last_conn_nxt = s1_now_r;
        ever_conn_nxt = 1'b1;
        if (!s1_fails_r) begin
          held_nxt   = 1'b1;
          status_nxt = ST_CONNECTING;
        end else begin
          held_nxt       = 1'b0;
          next_retry_nxt = retry_time;
          backoff_nxt    = bo_next;
          status_nxt     = ST_RETRYING;
        end
      end else begin
        status_nxt = retry_due ? ST_CONNECTING : ST_RETRYING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r    <= {4'd0, RST_BO_START};
      next_retry_r <= '0;
      last_conn_r  <= '0;
      ever_conn_r  <= 1'b0;
      sweep_cnt_r  <= '0;
      held_r       <= 1'b0;
      status_r     <= ST_NOKEY;
    end else if (adv) begin
      backoff_r    <= backoff_nxt;
      next_retry_r <= next_retry_nxt;
      last_conn_r  <= last_conn_nxt;
      ever_conn_r  <= ever_conn_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      held_r       <= held_nxt;
      status_r     <= status_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  status_t out_status_r;
  logic    out_drop_r, out_open_r, out_sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_drop_r   <= drop_nxt;
      out_open_r   <= open_nxt;
      out_sweep_r  <= sweep_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_drop_link = out_drop_r;
  assign out_open_link = out_open_r;
  assign out_sweep_now = out_sweep_r;

`ifndef ASSERT_OFF
  // an open beat always reports connecting or retrying
  a_open_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_open_r |->
      (out_status_r == ST_CONNECTING) || (out_status_r == ST_RETRYING))
    else $error("open pulse with unexpected status");

  // no sweep while offline, keyless or disabled
  a_sweep_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sweep_r |->
      (out_status_r != ST_OFFLINE) && (out_status_r != ST_NOKEY) &&
      (out_status_r != ST_DISABLED))
    else $error("sweep pulse on inactive tick");

  // a link only becomes held through an open
  a_held_by_open: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_r) |-> out_valid_r && out_open_r)
    else $error("link held without open pulse");

  // a processed beat always lands in the result register
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed beat lost");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for link_reconnect_backoff_controller_unit: ticks in,
// one status/pulse beat out per tick, checked against an in-bench predictor.
// Depends on lrbc_pkg and the unit under test only.
module tb_top;
  import lrbc_pkg::*;

  localparam logic [26:0] ALT_TOP  = '1;
  localparam int          SPAN_TOP = 36000;

  // one tick beat on the input side
  typedef struct {
    logic        enabled;
    logic [31:0] now;
    logic [26:0] alt;
    logic [15:0] span;
    logic        closed;
    logic        opened;
    logic        resub;
    logic        fails;
  } tick_t;

  // one result beat: status plus the three pulses
  typedef struct {
    status_t status;
    logic    drop;
    logic    open;
    logic    sweep;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_enabled = 1'b0;
  logic [31:0] in_now_sec = '0;
  logic [26:0] in_cam_alt_m = '0;
  logic [15:0] in_lon_span_centideg = '0;
  logic        in_link_closed = 1'b0;
  logic        in_link_opened = 1'b0;
  logic        in_needs_resubscribe = 1'b0;
  logic        in_open_fails = 1'b0;
  logic        in_ready;

  logic    out_valid;
  logic    out_ready = 1'b0;
  status_t out_status;
  logic    out_drop_link;
  logic    out_open_link;
  logic    out_sweep_now;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // ---------------------------------------------------------------------------
  // Bench-side copy of the register file, updated when an APB write lands.
  // ---------------------------------------------------------------------------
  logic        r_offline  = 1'b0;
  logic        r_key      = 1'b0;
  logic [7:0]  r_bo_start = RST_BO_START;
  logic [11:0] r_bo_cap   = RST_BO_CAP;
  logic [7:0]  r_cooldown = RST_COOLDOWN;
  logic [7:0]  r_sweep    = RST_SWEEP;
  logic [26:0] r_alt      = RST_ALT;
  logic [15:0] r_span     = RST_SPAN;

  // ---------------------------------------------------------------------------
  // Predicted controller state (reset values).
  // ---------------------------------------------------------------------------
  logic [11:0] backoff_now = 12'd5;
  time_t       retry_at    = '0;
  time_t       last_try_at = '0;
  logic        tried_once  = 1'b0;  // no attempt yet: cooldown is always met
  logic        link_up     = 1'b0;
  logic [7:0]  sweep_div   = '0;
  status_t     status_now  = ST_NOKEY;

  tick_t    tick_q[$];     // ticks waiting for the driver
  verdict_t verdict_q[$];  // predicted result beats, oldest first

  int  ticks_issued = 0;
  int  results_seen = 0;
  int  errors = 0;
  bit  calm = 1'b0;        // no idling on either side while set
  bit  hold_req = 1'b0;    // asks the receiver for its one long hold-off
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  logic [31:0] wall_sec = 32'd1000;  // bench wall clock for random ticks

  always #2 clk = ~clk;

  link_reconnect_backoff_controller_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_enabled           (in_enabled),
    .in_now_sec           (in_now_sec),
    .in_cam_alt_m         (in_cam_alt_m),
    .in_lon_span_centideg (in_lon_span_centideg),
    .in_link_closed       (in_link_closed),
    .in_link_opened       (in_link_opened),
    .in_needs_resubscribe (in_needs_resubscribe),
    .in_open_fails        (in_open_fails),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_drop_link        (out_drop_link),
    .out_open_link        (out_open_link),
    .out_sweep_now        (out_sweep_now),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Strictly more than the cooldown since the last attempt; a clock that has
  // gone backwards never satisfies it.
  function automatic bit cooldown_met(time_t now);
    if (!tried_once) return 1'b1;
    if (now < last_try_at) return 1'b0;
    return (now - last_try_at) > {24'd0, r_cooldown};
  endfunction

  // Retry after the current backoff (saturating at the top of the timebase),
  // then double the backoff up to the cap.
  function automatic void arm_retry(time_t now);
    logic [TIME_BITS:0] due;
    logic [12:0]        dbl;
    due = {1'b0, now} + {{(TIME_BITS-11){1'b0}}, backoff_now};
    retry_at = due[TIME_BITS] ? '1 : due[TIME_BITS-1:0];
    dbl = {backoff_now, 1'b0};
    backoff_now = (dbl < {1'b0, r_bo_cap}) ? dbl[11:0] : r_bo_cap;
    status_now = ST_RETRYING;
  endfunction

  // An open is issued; a failed one is never held and goes straight to retry.
  function automatic void launch_open(time_t now, logic fails);
    last_try_at = now;
    tried_once = 1'b1;
    if (!fails) begin
      link_up = 1'b1;
      status_now = ST_CONNECTING;
    end else begin
      link_up = 1'b0;
      arm_retry(now);
    end
  endfunction

  function automatic verdict_t judge_tick(tick_t k);
    verdict_t   v;
    logic [8:0] n;
    v.drop = 1'b0;
    v.open = 1'b0;
    v.sweep = 1'b0;
    if (r_offline) begin
      status_now = ST_OFFLINE;           // link left alone, no pulses
    end else if (!r_key) begin
      status_now = ST_NOKEY;
    end else if (!k.enabled) begin
      if (link_up) begin
        v.drop = 1'b1;
        link_up = 1'b0;
      end
      status_now = ST_DISABLED;          // divider frozen while disabled
    end else begin
      // period zero still pulses every active tick
      n = {1'b0, sweep_div} + 9'd1;
      if (n >= {1'b0, r_sweep}) begin
        sweep_div = '0;
        v.sweep = 1'b1;
      end else begin
        sweep_div = n[7:0];
      end

      if (k.alt > r_alt || k.span > r_span) begin
        if (link_up) begin
          v.drop = 1'b1;
          link_up = 1'b0;
        end
        status_now = ST_ZOOMED;
      end else if (link_up) begin
        if (k.closed) begin
          v.drop = 1'b1;
          link_up = 1'b0;
          arm_retry(k.now);
        end else if (k.opened) begin
          backoff_now = {4'd0, r_bo_start};
          status_now = ST_CONNECTED;
          // resubscribe: drop and reopen in one tick, cooldown still applies
          if (k.resub && cooldown_met(k.now)) begin
            v.drop = 1'b1;
            link_up = 1'b0;
            launch_open(k.now, k.fails);
            v.open = 1'b1;
          end
        end else begin
          status_now = ST_CONNECTING;
        end
      end else if (k.now >= retry_at && cooldown_met(k.now)) begin
        launch_open(k.now, k.fails);
        v.open = 1'b1;
      end else begin
        status_now = (k.now < retry_at) ? ST_RETRYING : ST_CONNECTING;
      end
    end
    v.status = status_now;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tick_t tick_of(logic en, logic [31:0] now, logic [26:0] alt,
                                    logic [15:0] span, logic closed, logic opened,
                                    logic resub, logic fails);
    tick_t k;
    k.enabled = en;
    k.now = now;
    k.alt = alt;
    k.span = span;
    k.closed = closed;
    k.opened = opened;
    k.resub = resub;
    k.fails = fails;
    return k;
  endfunction

  // Random tick from a mostly-forward wall clock. Steps scale with cooldown
  // and cap so retries and reopens actually come due; gate fields sit mostly
  // under the limits so links get held long enough to reach connected.
  function automatic tick_t next_tick();
    tick_t       k;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2)
      wall_sec += $urandom_range(0, 8000);
    else if (r < 3)
      wall_sec -= $urandom_range(0, 300);   // short step backwards
    else
      wall_sec += $urandom_range(0, 2 + r_cooldown / 8 + r_bo_cap / 64);
    k.now = wall_sec;
    k.enabled = ($urandom_range(0, 99) < 92);

    r = $urandom_range(0, 19);
    if (r < 18)
      k.alt = 27'($urandom_range(0, r_alt));
    else if (r == 18 && r_alt != ALT_TOP)
      k.alt = 27'($urandom_range(r_alt + 27'd1, ALT_TOP));
    else
      k.alt = 27'($urandom_range(0, ALT_TOP));

    r = $urandom_range(0, 19);
    if (r < 18)
      k.span = 16'($urandom_range(0, r_span));
    else if (r == 18 && r_span < SPAN_TOP)
      k.span = 16'($urandom_range(r_span + 1, SPAN_TOP));
    else
      k.span = 16'($urandom_range(0, SPAN_TOP));

    k.closed = ($urandom_range(0, 99) < 12);
    k.opened = ($urandom_range(0, 99) < 60);
    k.resub = ($urandom_range(0, 99) < 20);
    k.fails = ($urandom_range(0, 99) < 25);
    return k;
  endfunction

  function automatic void queue_tick(tick_t k);
    tick_q.insert(tick_q.size(), k);
    ticks_issued++;
  endfunction

  task automatic report_fault(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // APB write: setup, then access; lands on the edge with pready high.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OFFLINE:  r_offline  = val[0];
      REG_KEY:      r_key      = val[0];
      REG_BO_START: r_bo_start = val[7:0];
      REG_BO_CAP:   r_bo_cap   = val[11:0];
      REG_COOLDOWN: r_cooldown = val[7:0];
      REG_SWEEP:    r_sweep    = val[7:0];
      REG_ALT:      r_alt      = val[26:0];
      REG_SPAN:     r_span     = val[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic off, input logic key, input logic [7:0] bo_start,
                              input logic [11:0] bo_cap, input logic [7:0] cool,
                              input logic [7:0] sweep, input logic [26:0] alt,
                              input logic [15:0] span);
    apb_write(REG_OFFLINE,  {31'd0, off});
    apb_write(REG_KEY,      {31'd0, key});
    apb_write(REG_BO_START, {24'd0, bo_start});
    apb_write(REG_BO_CAP,   {20'd0, bo_cap});
    apb_write(REG_COOLDOWN, {24'd0, cool});
    apb_write(REG_SWEEP,    {24'd0, sweep});
    apb_write(REG_ALT,      {5'd0, alt});
    apb_write(REG_SPAN,     {16'd0, span});
  endtask

  // Wait until every queued tick has produced its checked beat, then let the
  // clock run on before touching registers.
  task automatic settle();
    @(posedge clk);
    while (results_seen < ticks_issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) queue_tick(next_tick());
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one assignment per signal per edge; valid holds until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        nxt = tick_q.pop_front();
        in_valid <= 1'b1;
        in_enabled <= nxt.enabled;
        in_now_sec <= nxt.now;
        in_cam_alt_m <= nxt.alt;
        in_lon_span_centideg <= nxt.span;
        in_link_closed <= nxt.closed;
        in_link_opened <= nxt.opened;
        in_needs_resubscribe <= nxt.resub;
        in_open_fails <= nxt.fails;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the unit backs up
  // and drops in_ready while the driver keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 150;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted tick, then checks any result beat
  // against the oldest prediction (predict first, so ordering never matters).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    tick_t    seen;
    verdict_t want;
    if (rst_n && in_valid && in_ready) begin
      seen = tick_of(in_enabled, in_now_sec, in_cam_alt_m, in_lon_span_centideg,
                     in_link_closed, in_link_opened, in_needs_resubscribe,
                     in_open_fails);
      verdict_q.insert(verdict_q.size(), judge_tick(seen));
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        report_fault($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        want = verdict_q.pop_front();
        if (out_status !== want.status)
          report_fault($sformatf("beat %0d: status %0d, expected %0d",
                                 results_seen, out_status, want.status));
        if (out_drop_link !== want.drop)
          report_fault($sformatf("beat %0d: drop_link %b, expected %b",
                                 results_seen, out_drop_link, want.drop));
        if (out_open_link !== want.open)
          report_fault($sformatf("beat %0d: open_link %b, expected %b",
                                 results_seen, out_open_link, want.open));
        if (out_sweep_now !== want.sweep)
          report_fault($sformatf("beat %0d: sweep_now %b, expected %b",
                                 results_seen, out_sweep_now, want.sweep));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset there is no key: extremes of every field, no link activity.
    queue_tick(tick_of(1, 32'hFFFF_FFFF, ALT_TOP, SPAN_TOP, 1, 1, 1, 1));
    queue_tick(tick_of(0, 32'd0, 27'd0, 16'd0, 0, 0, 0, 0));
    settle();

    // Offline mode wins over everything.
    program_regs(1, 1, RST_BO_START, RST_BO_CAP, RST_COOLDOWN, RST_SWEEP, RST_ALT, RST_SPAN);
    queue_tick(tick_of(1, 32'd100, 27'd0, 16'd0, 0, 0, 0, 0));
    settle();

    // Walk the state machine by hand with the reset settings
    // (backoff 5, cap 60, cooldown 10).
    apb_write(REG_OFFLINE, 32'd0);
    queue_tick(tick_of(0, 32'd100, 27'd0, 16'd0, 0, 0, 0, 0));       // disabled
    queue_tick(tick_of(1, 32'd100, ALT_TOP, 16'd0, 0, 0, 0, 0));     // too high
    queue_tick(tick_of(1, 32'd100, 27'd0, SPAN_TOP, 0, 0, 0, 0));    // too wide
    queue_tick(tick_of(1, 32'd100, 27'd0, 16'd0, 0, 0, 0, 1));       // first open fails
    queue_tick(tick_of(1, 32'd102, 27'd0, 16'd0, 0, 0, 0, 0));       // waiting on backoff
    queue_tick(tick_of(1, 32'd105, 27'd0, 16'd0, 0, 0, 0, 0));       // due, cooldown not
    queue_tick(tick_of(1, 32'd111, 27'd0, 16'd0, 0, 0, 0, 0));       // open succeeds
    queue_tick(tick_of(1, 32'd111, 27'd0, 16'd0, 0, 0, 0, 0));       // still handshaking
    queue_tick(tick_of(1, 32'd112, 27'd0, 16'd0, 0, 1, 0, 0));       // connected
    queue_tick(tick_of(1, 32'd113, 27'd0, 16'd0, 0, 1, 1, 0));       // resub, too soon
    queue_tick(tick_of(1, 32'd122, 27'd0, 16'd0, 0, 1, 1, 0));       // resub reopen
    queue_tick(tick_of(1, 32'd123, 27'd0, 16'd0, 1, 0, 0, 0));       // closed -> retry
    queue_tick(tick_of(1, 32'd90, 27'd0, 16'd0, 0, 0, 0, 0));        // clock went back
    queue_tick(tick_of(1, 32'd140, 27'd0, 16'd0, 0, 1, 1, 0));       // flags with no link
    queue_tick(tick_of(1, 32'd141, 27'd0, 16'd0, 0, 1, 0, 0));
    queue_tick(tick_of(0, 32'd142, 27'd0, 16'd0, 0, 1, 0, 0));       // disable drops link
    queue_tick(tick_of(1, 32'd160, 27'd0, 16'd0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 32'd161, 27'd0, 16'd0, 0, 1, 0, 0));
    queue_tick(tick_of(1, 32'd162, ALT_TOP, 16'd0, 0, 1, 0, 0));     // zoom drops link
    queue_tick(tick_of(1, 32'd175, 27'd0, 16'd0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 32'd190, 27'd0, 16'd0, 0, 1, 1, 1));       // reopen fails
    queue_tick(tick_of(1, 32'd191, 27'd0, 16'd0, 0, 0, 0, 0));
    settle();

    // Reset settings with no idling anywhere.
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;

    // Low extremes: everything gated unless alt and span are zero.
    program_regs(0, 1, 8'd1, 12'd1, 8'd0, 8'd1, 27'd0, 16'd0);
    run_random(120);

    // High extremes: long backoffs and cooldowns, sweep rarely.
    program_regs(0, 1, 8'd255, 12'd4095, 8'd255, 8'd255, ALT_TOP, SPAN_TOP[15:0]);
    run_random(150);

    // Zero cap and zero sweep period; the long receiver hold-off lands here.
    program_regs(0, 1, 8'($urandom_range(1, 20)), 12'd0, 8'd3, 8'd0, RST_ALT, RST_SPAN);
    hold_req = 1'b1;
    run_random(120);

    program_regs(1, 0, RST_BO_START, RST_BO_CAP, RST_COOLDOWN, RST_SWEEP, RST_ALT, RST_SPAN);
    run_random(60);
    program_regs(0, 0, RST_BO_START, RST_BO_CAP, RST_COOLDOWN, RST_SWEEP, RST_ALT, RST_SPAN);
    run_random(60);

    // Mixed random settings, weighted toward values that keep links cycling.
    for (int p = 0; p < 10; p++) begin
      program_regs($urandom_range(0, 19) == 0,
                   $urandom_range(0, 19) != 0,
                   8'($urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(0, 255)),
                   12'($urandom_range(0, 1) ? $urandom_range(1, 120) :
                                             $urandom_range(0, 4095)),
                   8'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255)),
                   8'($urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(0, 255)),
                   27'($urandom_range(0, ALT_TOP)),
                   16'($urandom_range(0, SPAN_TOP)));
      run_random(110);
    end

    // Top of the timebase last: an attempt up there blocks all later opens,
    // so it only happens once nothing else depends on reconnecting.
    program_regs(0, 1, 8'd200, 12'd4095, 8'd10, 8'd3, ALT_TOP, SPAN_TOP[15:0]);
    queue_tick(tick_of(0, wall_sec, 27'd0, 16'd0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 32'hFFFF_FFF0, 27'd0, 16'd0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 32'hFFFF_FFF1, 27'd0, 16'd0, 0, 1, 0, 0));
    queue_tick(tick_of(1, 32'hFFFF_FFF2, 27'd0, 16'd0, 1, 0, 0, 0));  // retry saturates
    queue_tick(tick_of(1, 32'hFFFF_FFFF, 27'd0, 16'd0, 0, 0, 0, 1));
    repeat (30)
      queue_tick(tick_of(1'($urandom_range(0, 1)), $urandom(),
                         27'($urandom_range(0, ALT_TOP)),
                         16'($urandom_range(0, SPAN_TOP)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))));
    settle();

    if (verdict_q.size() != 0)
      report_fault($sformatf("%0d predicted beats never arrived", verdict_q.size()));
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/lrbc_pkg.sv
rtl/link_reconnect_backoff_controller_unit.sv
tb/tb_top.sv
